// ===== rtl/i64alu_pkg.sv =====
// shared types, codes and constants of the integer alu with power
`default_nettype none
package i64alu_pkg;

	localparam int DATA_WIDTH = 64;
	// multiplier bits retired per cycle by the shared multiplier
	localparam int MUL_DIGIT = 8;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_POW = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNHANDLED = 2'd1,
		ST_DIVZERO   = 2'd2
	} st_t;

	// work class of a captured item
	typedef enum logic [1:0] {
		CL_QUICK = 2'd0,
		CL_MUL   = 2'd1,
		CL_DIV   = 2'd2,
		CL_POW   = 2'd3
	} cls_t;

	// multiplier operand pairs
	typedef enum logic [1:0] {
		MS_AB = 2'd0,
		MS_RB = 2'd1,
		MS_BB = 2'd2
	} ms_t;

	typedef struct packed {
		logic load;
		logic res_quick;
		logic mul_start;
		ms_t  mul_src;
		logic div_start;
		logic pow_init;
		logic r_wr;
		logic base_wr;
		logic e_shift;
		logic res_mul;
		logic res_div;
		logic res_pow;
		logic out_load;
	} dp_ctl_t;

	typedef struct packed {
		cls_t cls;
		logic mul_done;
		logic div_done;
		logic e_zero;
		logic e_lsb;
		logic e_one;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/int64_alu_with_power_top.sv =====
// top level of the signed integer alu with add, subtract, multiply, divide and power
`default_nettype none
// Signed two's complement alu at DATA_WIDTH bits (64 by default). Each input
// transfer carries an opcode (0 add, 1 subtract, 2 multiply, 3 divide,
// 4 power), two operands and one integer flag per operand; each gives exactly
// one output transfer of a status (0 ok, 1 not handled, 2 divide by zero) and
// a value that is sign-extended to 64 bits and is zero unless status is ok.
// Operand bits above DATA_WIDTH are ignored. One item is in work at a time:
// in_stall is high from the transfer until the result has moved to the output
// register, and a new item may be taken while that register still waits on
// out_stall. Add, subtract, non-integer operands, unused opcodes and zero
// divisors are settled in the decode state; multiply time grows with the
// number of significant bytes of operand_b (at least 1, at most
// ceil(DATA_WIDTH/8)), as the shared multiplier retires 8 multiplier bits
// per cycle; divide runs on the restoring divider that yields one quotient
// bit per cycle; power runs square-and-multiply on the shared multiplier,
// with a multiply for each set exponent bit and a square for each bit but
// the last. A zero or negative exponent gives 1. Input transfers resume in
// the cycle right after each output register load.
module int64_alu_with_power_top import i64alu_pkg::*; #(
	parameter int DATA_W = DATA_WIDTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  cmd,
	input  wire logic        a_is_integer,
	input  wire logic        b_is_integer,
	input  wire logic [63:0] operand_a,
	input  wire logic [63:0] operand_b,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [63:0]      result_value
);

	dp_ctl_t dp_ctl;
	dp_sts_t dp_sts;

	// sequencing of each item and both handshakes
	i64alu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_sts    (dp_sts),
		.dp_ctl    (dp_ctl)
	);

	// operand capture, arithmetic units and the output register
	i64alu_dp #(.W(DATA_W)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.a_is_integer (a_is_integer),
		.b_is_integer (b_is_integer),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.dp_ctl       (dp_ctl),
		.dp_sts       (dp_sts),
		.status       (status),
		.result_value (result_value)
	);

endmodule
`default_nettype wire

// ===== rtl/i64alu_mul.sv =====
// iterative wrapping multiplier, one digit of the multiplier per cycle
`default_nettype none
module i64alu_mul import i64alu_pkg::*; #(
	parameter int W = DATA_WIDTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] mcand,
	input  wire logic [W-1:0] mplier,
	output logic      [W-1:0] product,
	output logic              done
);

	logic [W-1:0]           mcand_q;
	logic [W-1:0]           mplier_q;
	logic [W-1:0]           acc_q;
	logic                   busy_q;
	logic                   done_q;
	logic [W+MUL_DIGIT-1:0] pp;
	logic [W-1:0]           mplier_nx;

	assign pp        = mcand_q * mplier_q[MUL_DIGIT-1:0];
	assign mplier_nx = mplier_q >> MUL_DIGIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && mplier_nx == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			acc_q    <= '0;
		end else if (busy_q) begin
			acc_q    <= acc_q + pp[W-1:0];
			mcand_q  <= mcand_q << MUL_DIGIT;
			mplier_q <= mplier_nx;
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule
`default_nettype wire

// ===== rtl/i64alu_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module i64alu_div import i64alu_pkg::*; #(
	parameter int W = DATA_WIDTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic      [W-1:0] quotient,
	output logic              done
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic [W:0]    trial;

	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= trial[W] ? shifted[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ~trial[W]};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule
`default_nettype wire

// ===== rtl/i64alu_dp.sv =====
// datapath: item registers, quick ops, power registers, result and output registers
`default_nettype none
module i64alu_dp import i64alu_pkg::*; #(
	parameter int W = DATA_WIDTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [2:0]  cmd,
	input  wire logic        a_is_integer,
	input  wire logic        b_is_integer,
	input  wire logic [63:0] operand_a,
	input  wire logic [63:0] operand_b,
	input  wire dp_ctl_t     dp_ctl,
	output dp_sts_t          dp_sts,
	output logic [1:0]       status,
	output logic [63:0]      result_value
);

	logic [2:0]   op_q;
	logic         ai_q;
	logic         bi_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic [W-1:0] r_q;
	logic [W-1:0] base_q;
	logic [W-1:0] e_q;
	logic         neg_q;
	logic [W-1:0] res_val_q;
	st_t          res_st_q;
	logic [1:0]   out_st_q;
	logic [63:0]  out_val_q;

	logic [W-1:0] a_mag;
	logic [W-1:0] b_mag;
	logic [W-1:0] sum;
	logic [W-1:0] mul_a;
	logic [W-1:0] mul_b;
	logic [W-1:0] mul_p;
	logic         mul_done;
	logic [W-1:0] quo;
	logic         div_done;
	logic         b_zero;
	cls_t         cls;
	logic [W-1:0] quick_val;
	st_t          quick_st;

	assign a_mag  = a_q[W-1] ? W'(-a_q) : a_q;
	assign b_mag  = b_q[W-1] ? W'(-b_q) : b_q;
	assign b_zero = (b_q == '0);
	assign sum    = (op_q == OP_SUB) ? W'(a_q - b_q) : W'(a_q + b_q);

	// classify the captured item
	always_comb begin
		quick_val = '0;
		quick_st  = ST_UNHANDLED;
		cls       = CL_QUICK;
		if (ai_q && bi_q) begin
			unique case (op_q) inside
				OP_ADD, OP_SUB: begin
					quick_val = sum;
					quick_st  = ST_OK;
				end
				OP_MUL: cls = CL_MUL;
				OP_DIV: begin
					if (b_zero) begin
						quick_st = ST_DIVZERO;
					end else begin
						cls = CL_DIV;
					end
				end
				OP_POW: cls = CL_POW;
				default: quick_st = ST_UNHANDLED;
			endcase
		end
	end

	always_comb begin
		case (dp_ctl.mul_src)
			MS_RB: begin
				mul_a = r_q;
				mul_b = base_q;
			end
			MS_BB: begin
				mul_a = base_q;
				mul_b = base_q;
			end
			default: begin
				mul_a = a_q;
				mul_b = b_q;
			end
		endcase
	end

	i64alu_mul #(.W(W)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (dp_ctl.mul_start),
		.mcand   (mul_a),
		.mplier  (mul_b),
		.product (mul_p),
		.done    (mul_done)
	);

	i64alu_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dp_ctl.div_start),
		.dividend (a_mag),
		.divisor  (b_mag),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (dp_ctl.load) begin
			op_q <= cmd;
			ai_q <= a_is_integer;
			bi_q <= b_is_integer;
			a_q  <= operand_a[W-1:0];
			b_q  <= operand_b[W-1:0];
		end
		if (dp_ctl.div_start) begin
			neg_q <= a_q[W-1] ^ b_q[W-1];
		end
		// power: negative exponent behaves as zero
		if (dp_ctl.pow_init) begin
			r_q    <= W'(1);
			base_q <= a_q;
			e_q    <= b_q[W-1] ? '0 : b_q;
		end else begin
			if (dp_ctl.r_wr) begin
				r_q <= mul_p;
			end
			if (dp_ctl.base_wr) begin
				base_q <= mul_p;
			end
			if (dp_ctl.e_shift) begin
				e_q <= e_q >> 1;
			end
		end
		if (dp_ctl.res_quick) begin
			res_val_q <= quick_val;
			res_st_q  <= quick_st;
		end else if (dp_ctl.res_mul) begin
			res_val_q <= mul_p;
			res_st_q  <= ST_OK;
		end else if (dp_ctl.res_div) begin
			res_val_q <= neg_q ? W'(-quo) : quo;
			res_st_q  <= ST_OK;
		end else if (dp_ctl.res_pow) begin
			res_val_q <= r_q;
			res_st_q  <= ST_OK;
		end
		if (dp_ctl.out_load) begin
			out_st_q  <= res_st_q;
			out_val_q <= 64'(signed'(res_val_q));
		end
	end

	assign dp_sts.cls      = cls;
	assign dp_sts.mul_done = mul_done;
	assign dp_sts.div_done = div_done;
	assign dp_sts.e_zero   = (e_q == '0);
	assign dp_sts.e_lsb    = e_q[0];
	assign dp_sts.e_one    = (e_q == W'(1));

	assign status       = out_st_q;
	assign result_value = out_val_q;

endmodule
`default_nettype wire

// ===== rtl/i64alu_ctrl.sv =====
// controller state machine and handshake of the integer alu with power
`default_nettype none
module i64alu_ctrl import i64alu_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  wire logic    out_stall,
	input  wire dp_sts_t dp_sts,
	output dp_ctl_t      dp_ctl
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_DEC  = 9'b000000010,
		S_MUL  = 9'b000000100,
		S_DIV  = 9'b000001000,
		S_PCHK = 9'b000010000,
		S_PMR  = 9'b000100000,
		S_PSQ  = 9'b001000000,
		S_PSW  = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nx = state_q;
		dp_ctl   = '0;
		dp_ctl.mul_src = MS_AB;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dp_ctl.load = 1'b1;
					state_nx    = S_DEC;
				end
			end
			S_DEC: begin
				unique case (dp_sts.cls)
					CL_MUL: begin
						dp_ctl.mul_start = 1'b1;
						state_nx         = S_MUL;
					end
					CL_DIV: begin
						dp_ctl.div_start = 1'b1;
						state_nx         = S_DIV;
					end
					CL_POW: begin
						dp_ctl.pow_init = 1'b1;
						state_nx        = S_PCHK;
					end
					default: begin
						dp_ctl.res_quick = 1'b1;
						state_nx         = S_FIN;
					end
				endcase
			end
			S_MUL: begin
				if (dp_sts.mul_done) begin
					dp_ctl.res_mul = 1'b1;
					state_nx       = S_FIN;
				end
			end
			S_DIV: begin
				if (dp_sts.div_done) begin
					dp_ctl.res_div = 1'b1;
					state_nx       = S_FIN;
				end
			end
			S_PCHK: begin
				if (dp_sts.e_zero) begin
					dp_ctl.res_pow = 1'b1;
					state_nx       = S_FIN;
				end else if (dp_sts.e_lsb) begin
					dp_ctl.mul_start = 1'b1;
					dp_ctl.mul_src   = MS_RB;
					state_nx         = S_PMR;
				end else begin
					state_nx = S_PSQ;
				end
			end
			S_PMR: begin
				if (dp_sts.mul_done) begin
					dp_ctl.r_wr = 1'b1;
					state_nx    = S_PSQ;
				end
			end
			S_PSQ: begin
				// last exponent bit needs no further squaring
				if (dp_sts.e_one) begin
					dp_ctl.e_shift = 1'b1;
					state_nx       = S_PCHK;
				end else begin
					dp_ctl.mul_start = 1'b1;
					dp_ctl.mul_src   = MS_BB;
					state_nx         = S_PSW;
				end
			end
			S_PSW: begin
				if (dp_sts.mul_done) begin
					dp_ctl.base_wr = 1'b1;
					dp_ctl.e_shift = 1'b1;
					state_nx       = S_PCHK;
				end
			end
			S_FIN: begin
				if (out_free) begin
					dp_ctl.out_load = 1'b1;
					state_nx        = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (dp_ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== tb/tb_int64_alu_with_power_top.sv =====
// testbench of the signed 64-bit integer alu with power: directed corners, random mix, self-check
`timescale 1ns / 1ps
module tb_int64_alu_with_power_top;
	import i64alu_pkg::*;

	// opcodes the block leaves unhandled
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	localparam logic [63:0] WORD_MIN  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] WORD_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] WORD_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	// power items are the slowest kind of item
	localparam int CYCLE_LIMIT = 4_000_000;
	// quiet time after the last result, long enough for a full power pass
	localparam int TAIL_CYCLES = 1400;

	typedef struct packed {
		st_t         status;
		logic [63:0] value;
	} alu_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  cmd = '0;
	logic        a_is_integer = 1'b0;
	logic        b_is_integer = 1'b0;
	logic [63:0] operand_a = '0;
	logic [63:0] operand_b = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [63:0] result_value;

	// results predicted for accepted transfers, oldest first
	alu_result_t pending_results[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          stall_left = 0;
	// set while both sides must run without any idling
	bit          quiet_mode = 1'b0;

	int64_alu_with_power_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.a_is_integer (a_is_integer),
		.b_is_integer (b_is_integer),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.result_value (result_value)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// keep the low DATA_WIDTH bits and sign-extend them to 64
	function automatic logic [63:0] fit_width(input logic [63:0] x);
		logic [63:0] v;
		v = x;
		for (int i = DATA_WIDTH; i < 64; i++)
			v[i] = x[DATA_WIDTH-1];
		return v;
	endfunction

	// square-and-multiply, every product wrapped
	function automatic logic [63:0] raise_power(input logic [63:0] base, input logic [63:0] expo);
		logic [63:0] acc;
		acc = 64'd1;
		// negative exponent gives one
		if (expo[63])
			return 64'd1;
		while (expo != 0) begin
			if (expo[0])
				acc = fit_width(acc * base);
			base = fit_width(base * base);
			expo = expo >> 1;
		end
		return fit_width(acc);
	endfunction

	function automatic alu_result_t predict_alu(input logic [2:0] op_code, input logic a_int,
			input logic b_int, input logic [63:0] a_raw, input logic [63:0] b_raw);
		alu_result_t res;
		logic [63:0] a, b, mag_a, mag_b, quo;
		res.status = ST_OK;
		res.value = '0;
		a = fit_width(a_raw);
		b = fit_width(b_raw);
		// non-integer operands win over everything else
		if (!(a_int && b_int)) begin
			res.status = ST_UNHANDLED;
		end else begin
			case (op_code)
				OP_ADD: res.value = fit_width(a + b);
				OP_SUB: res.value = fit_width(a - b);
				OP_MUL: res.value = fit_width(a * b);
				OP_DIV: begin
					if (b == 0) begin
						res.status = ST_DIVZERO;
					end else begin
						// truncate toward zero on magnitudes, then fix the sign
						mag_a = a[63] ? -a : a;
						mag_b = b[63] ? -b : b;
						quo = mag_a / mag_b;
						if (a[63] != b[63])
							quo = -quo;
						res.value = fit_width(quo);
					end
				end
				OP_POW: res.value = raise_power(a, b);
				default: res.status = ST_UNHANDLED;
			endcase
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// compare every output transfer with the oldest prediction
	always @(posedge clk) begin : check_results
		alu_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result, status %0d value %h",
					status, result_value));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, predicted %0d",
						status, want.status));
				if (result_value !== want.value)
					report_mismatch($sformatf("value %h, predicted %h",
						result_value, want.value));
			end
		end
	end

	// output side back-pressure: rare stalled stretches, about 7% overall
	always @(posedge clk) begin
		if (quiet_mode) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 999) < 4) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 39);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run stopped at cycle limit with %0d results pending",
				pending_results.size());
			$display("int64_alu_with_power_top test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	// one input transfer; valid stays high afterwards so back-to-back items need no toggle
	task automatic send_op(input logic [2:0] op_code, input logic a_int, input logic b_int,
			input logic [63:0] a_val, input logic [63:0] b_val);
		// occasional sender gap of random length, so the next valid lands on any phase
		if (!quiet_mode && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op_code;
		a_is_integer <= a_int;
		b_is_integer <= b_int;
		operand_a <= a_val;
		operand_b <= b_val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// transfer taken at this edge
		pending_results.push_back(predict_alu(op_code, a_int, b_int, a_val, b_val));
	endtask

	// sender holds off until every predicted result has come back
	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_operand();
		logic [63:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = rand64();
			4, 5: v = 64'($urandom_range(0, 64)) - 64'd32;
			6: begin
				case ($urandom_range(0, 4))
					0: v = WORD_MIN;
					1: v = WORD_MAX;
					2: v = '0;
					3: v = 64'd1;
					default: v = WORD_ONES;
				endcase
			end
			7: begin
				v = 64'd1 << $urandom_range(0, 63);
				if ($urandom_range(0, 1))
					v = -v;
			end
			// few significant bytes, to vary the multiplier pass length
			default: begin
				v = rand64() >> $urandom_range(1, 63);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	// mostly short exponents keep power items cheap; a few take the full width
	function automatic logic [63:0] pick_exponent();
		logic [63:0] v;
		case ($urandom_range(0, 19))
			0: v = rand64();
			1, 2: v = rand64() | WORD_MIN;
			3, 4: v = 64'($urandom_range(41, 200));
			default: v = 64'($urandom_range(0, 40));
		endcase
		return v;
	endfunction

	task automatic send_random_item();
		logic [2:0]  op_code;
		logic        a_int, b_int;
		logic [63:0] a_val, b_val;
		if ($urandom_range(0, 99) < 4)
			op_code = 3'($urandom_range(int'(CMD_SPARE_FIRST), int'(CMD_SPARE_LAST)));
		else
			op_code = 3'($urandom_range(int'(OP_ADD), int'(OP_POW)));
		a_int = ($urandom_range(0, 99) < 95) ? 1'b1 : 1'($urandom_range(0, 1));
		b_int = ($urandom_range(0, 99) < 95) ? 1'b1 : 1'($urandom_range(0, 1));
		a_val = pick_operand();
		b_val = (op_code == OP_POW) ? pick_exponent() : pick_operand();
		if (op_code == OP_DIV) begin
			case ($urandom_range(0, 19))
				0: b_val = '0;
				1: begin
					a_val = WORD_MIN;
					b_val = WORD_ONES;
				end
				default: ;
			endcase
		end
		send_op(op_code, a_int, b_int, a_val, b_val);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	task automatic test_add_sub_wrap();
		send_op(OP_ADD, 1'b1, 1'b1, WORD_MAX, 64'd1);
		send_op(OP_SUB, 1'b1, 1'b1, WORD_MIN, 64'd1);
		send_op(OP_SUB, 1'b1, 1'b1, '0, WORD_MIN);
	endtask

	task automatic test_multiply_extremes();
		send_op(OP_MUL, 1'b1, 1'b1, WORD_MIN, WORD_ONES);
		send_op(OP_MUL, 1'b1, 1'b1, WORD_MAX, WORD_MAX);
		send_op(OP_MUL, 1'b1, 1'b1, WORD_ONES, WORD_ONES);
	endtask

	task automatic test_divide_cases();
		send_op(OP_DIV, 1'b1, 1'b1, 64'd7, -64'd2);
		send_op(OP_DIV, 1'b1, 1'b1, -64'd7, 64'd2);
		// most negative over minus one wraps back to most negative
		send_op(OP_DIV, 1'b1, 1'b1, WORD_MIN, WORD_ONES);
		send_op(OP_DIV, 1'b1, 1'b1, 64'd12345, '0);
		send_op(OP_DIV, 1'b1, 1'b1, WORD_MIN, 64'd1);
	endtask

	task automatic test_power_cases();
		send_op(OP_POW, 1'b1, 1'b1, '0, '0);
		send_op(OP_POW, 1'b1, 1'b1, 64'd5, -64'd3);
		send_op(OP_POW, 1'b1, 1'b1, 64'd3, 64'd40);
		send_op(OP_POW, 1'b1, 1'b1, -64'd2, 64'd63);
		send_op(OP_POW, 1'b1, 1'b1, WORD_MIN, 64'd2);
		// longest exponent: every bit set below the sign
		send_op(OP_POW, 1'b1, 1'b1, WORD_ONES, WORD_MAX);
	endtask

	task automatic test_non_integer();
		send_op(OP_ADD, 1'b0, 1'b1, 64'd1, 64'd2);
		// flag check comes before the zero divisor
		send_op(OP_DIV, 1'b1, 1'b0, 64'd9, '0);
		send_op(OP_POW, 1'b0, 1'b0, 64'd2, 64'd10);
	endtask

	task automatic test_spare_opcodes();
		for (int op = int'(CMD_SPARE_FIRST); op <= int'(CMD_SPARE_LAST); op++)
			send_op(3'(op), 1'b1, 1'b1, rand64(), rand64());
	endtask

	task automatic test_random_mix(input int count);
		repeat (count)
			send_random_item();
	endtask

	// both sides run flat out for the whole stretch
	task automatic test_no_idle_burst(input int count);
		quiet_mode = 1'b1;
		repeat (count)
			send_random_item();
		quiet_mode = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_add_sub_wrap();
		test_multiply_extremes();
		test_divide_cases();
		test_power_cases();
		test_non_integer();
		test_spare_opcodes();
		test_random_mix(1400);
		// sender pauses until the block has drained completely
		wait_all_results();
		test_no_idle_burst(300);
		test_random_mix(150);

		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("int64_alu_with_power_top test passed");
		else
			$display("int64_alu_with_power_top test failed");
		$finish;
	end

endmodule

// ===== int64_alu_with_power_top.f =====
rtl/i64alu_pkg.sv
rtl/i64alu_mul.sv
rtl/i64alu_div.sv
rtl/i64alu_dp.sv
rtl/i64alu_ctrl.sv
rtl/int64_alu_with_power_top.sv
tb/tb_int64_alu_with_power_top.sv
